>>> rtl/variable_partition_allocator_unit_macros.svh
// Assertion macros for the variable partition allocator.
`ifndef VARIABLE_PARTITION_ALLOCATOR_UNIT_MACROS_SVH
`define VARIABLE_PARTITION_ALLOCATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define VPA_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VPA_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define VPA_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define VPA_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

>>> rtl/vpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpa_pkg
// Shared types and constants of the variable partition allocator.
// ----------------------------------------------------------------------------
package vpa_pkg;
    localparam int MEM_UNITS  = 32;
    localparam int OWNER_BITS = 8;
    localparam int IDX_W      = $clog2(MEM_UNITS);
    localparam int LEN_W      = $clog2(MEM_UNITS + 1);
    localparam int CNT_W      = $clog2(MEM_UNITS + 1);

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_NO_FIT   = 2'd1,
        ST_NO_OWNER = 2'd2,
        ST_ZERO     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        POL_FIRST = 2'd0,
        POL_BEST  = 2'd1,
        POL_WORST = 2'd2,
        POL_ALT   = 2'd3
    } policy_t;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef struct packed {
        logic [IDX_W-1:0]      start;
        logic [LEN_W-1:0]      len;
        logic [OWNER_BITS-1:0] owner;
        logic                  used;
    } seg_t;

    // Classified command from front to back.
    typedef struct packed {
        logic                  op;
        logic                  zero;
        logic [OWNER_BITS-1:0] owner;
        logic [5:0]            size;
    } cmd_t;

    typedef struct packed {
        status_t    status;
        logic [4:0] start_address;
        logic [5:0] segment_length;
    } rsp_t;
endpackage

>>> rtl/vpa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpa_if
// Valid/ready word channel carrying a packed payload.
// ----------------------------------------------------------------------------
interface vpa_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/vpa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpa_front
// Accepts request words, classifies them and queues them for the engine.
// ----------------------------------------------------------------------------
module vpa_front
    import vpa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_op,
    input  logic [7:0]       in_owner,
    input  logic [5:0]       in_size,
    output logic             q_valid,
    input  logic             q_pop,
    output cmd_t             q_cmd
);
    // two-entry queue
    cmd_t       q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, rd_next;
    logic       wr_ptr;
    logic       push;
    cmd_t       c;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = q_reg[rd_reg];
    assign wr_ptr   = rd_reg ^ cnt_reg[0];

    always_comb
    begin
        c.op    = in_op;
        c.owner = in_owner[OWNER_BITS-1:0];
        c.size  = in_size;
        c.zero  = (in_op == OP_ALLOC) && (in_size == 6'd0);
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
        rd_next  = rd_reg ^ q_pop;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr] <= c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
        end
    end
endmodule

>>> rtl/vpa_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpa_engine
// Scans the segment table, then shifts entries to split or merge.
// ----------------------------------------------------------------------------
module vpa_engine
    import vpa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  policy_t policy,
    input  logic    q_valid,
    output logic    q_pop,
    input  cmd_t    q_cmd,
    output logic    out_valid,
    input  logic    out_ready,
    output rsp_t    out_rsp
);
`include "variable_partition_allocator_unit_macros.svh"

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_APPLY = 5'b00100,
        S_SHIFT = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    // table rows are shifted in place, one row per cycle, so every row is a
    // register with a fixed neighbor
    seg_t             tab_reg [MEM_UNITS];
    logic [CNT_W-1:0] count_reg;
    state_t           state_reg, state_next;
    cmd_t             cmd_reg;
    logic [CNT_W-1:0] idx_reg;
    logic             found_reg;
    logic [IDX_W-1:0] pick_reg;
    logic [LEN_W-1:0] plen_reg;
    logic             sdir_reg;      // 1 insert (up), 0 remove (down) or nothing
    logic [CNT_W-1:0] sfrom_reg;     // insert: row that takes ins_reg; remove: new count
    seg_t             ins_reg;
    logic             merge_prev_reg; // remove pulls rows down by two
    rsp_t             rsp_reg;

    seg_t             cur;
    logic             elig;
    logic             better;
    logic [IDX_W-1:0] idx_i;

    assign idx_i   = idx_reg[IDX_W-1:0];
    assign cur     = tab_reg[idx_i];
    assign q_pop   = (state_reg == S_IDLE) && q_valid;
    assign out_valid = (state_reg == S_OUT);
    assign out_rsp   = rsp_reg;

    always_comb
    begin
        if (cmd_reg.op == OP_ALLOC)
            elig = !cur.used && ({1'b0, cur.len} >= {1'b0, cmd_reg.size[LEN_W-1:0]})
                   && (cmd_reg.size[5:LEN_W-1] == '0 || cmd_reg.size <= 6'(MEM_UNITS));
        else
            elig = cur.used && (cur.owner == cmd_reg.owner);
        better = !found_reg;
        if (found_reg && cmd_reg.op == OP_ALLOC)
        begin
            unique case (policy)
                POL_BEST:  better = cur.len < plen_reg;
                POL_WORST: better = cur.len > plen_reg;
                default:   better = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (q_valid) state_next = q_cmd.zero ? S_OUT : S_SCAN;
            S_SCAN:
            begin
                if (idx_reg + 1'b1 >= count_reg ||
                    (elig && !found_reg && (cmd_reg.op == OP_RELEASE ||
                     policy == POL_FIRST || policy == POL_ALT)))
                    state_next = S_APPLY;
            end
            S_APPLY: state_next = S_SHIFT;
            S_SHIFT: if (idx_reg == sfrom_reg) state_next = S_OUT;
            S_OUT:   if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= CNT_W'(1);
            tab_reg[0] <= '{start: '0, len: LEN_W'(MEM_UNITS), owner: '0, used: 1'b0};
            for (int k = 1; k < MEM_UNITS; k++)
                tab_reg[k] <= '0;
            found_reg      <= 1'b0;
            cmd_reg        <= '0;
            idx_reg        <= '0;
            pick_reg       <= '0;
            plen_reg       <= '0;
            sdir_reg       <= 1'b0;
            sfrom_reg      <= '0;
            ins_reg        <= '0;
            merge_prev_reg <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg   <= q_cmd;
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        rsp_reg   <= '{status: ST_ZERO, start_address: '0,
                                       segment_length: '0};
                    end
                end
                S_SCAN:
                begin
                    if (elig && better)
                    begin
                        found_reg <= 1'b1;
                        pick_reg  <= idx_i;
                        plen_reg  <= cur.len;
                    end
                    idx_reg <= idx_reg + 1'b1;
                end
                S_APPLY:
                begin
                    if (!found_reg)
                    begin
                        rsp_reg.status <= (cmd_reg.op == OP_ALLOC) ? ST_NO_FIT : ST_NO_OWNER;
                        sdir_reg       <= 1'b0;
                        merge_prev_reg <= 1'b0;
                        sfrom_reg <= count_reg;
                        idx_reg   <= count_reg;
                    end
                    else if (cmd_reg.op == OP_ALLOC)
                    begin
                        rsp_reg <= '{status: ST_DONE,
                                     start_address: 5'(tab_reg[pick_reg].start),
                                     segment_length: cmd_reg.size};
                        tab_reg[pick_reg].used  <= 1'b1;
                        tab_reg[pick_reg].owner <= cmd_reg.owner;
                        tab_reg[pick_reg].len   <= cmd_reg.size[LEN_W-1:0];
                        ins_reg <= '{start: IDX_W'(tab_reg[pick_reg].start + cmd_reg.size),
                                     len: plen_reg - cmd_reg.size[LEN_W-1:0],
                                     owner: '0, used: 1'b0};
                        merge_prev_reg <= 1'b0;
                        if (plen_reg != cmd_reg.size[LEN_W-1:0])
                        begin
                            sdir_reg  <= 1'b1;
                            sfrom_reg <= CNT_W'(pick_reg) + 1'b1;
                            idx_reg   <= count_reg;
                            count_reg <= count_reg + 1'b1;
                        end
                        else
                        begin
                            // exact fit: no remainder row
                            sdir_reg  <= 1'b0;
                            sfrom_reg <= count_reg;
                            idx_reg   <= count_reg;
                        end
                    end
                    else
                    begin
                        rsp_reg <= '{status: ST_DONE,
                                     start_address: 5'(tab_reg[pick_reg].start),
                                     segment_length: 6'(tab_reg[pick_reg].len)};
                        tab_reg[pick_reg].used  <= 1'b0;
                        tab_reg[pick_reg].owner <= '0;
                        sdir_reg <= 1'b0;
                        // merge is done by absorbing into the lower row and
                        // removing the rows above it; up to two removals
                        if (CNT_W'(pick_reg) + 1'b1 < count_reg &&
                            !tab_reg[pick_reg + 1'b1].used)
                        begin
                            if (pick_reg != '0 && !tab_reg[pick_reg - 1'b1].used)
                            begin
                                // both neighbors free: drop rows pick and pick+1
                                tab_reg[pick_reg - 1'b1].len <= tab_reg[pick_reg - 1'b1].len
                                    + tab_reg[pick_reg].len + tab_reg[pick_reg + 1'b1].len;
                                merge_prev_reg <= 1'b1;
                                idx_reg   <= CNT_W'(pick_reg);
                                sfrom_reg <= count_reg - 2'd2;
                                count_reg <= count_reg - 2'd2;
                            end
                            else
                            begin
                                tab_reg[pick_reg].len <= tab_reg[pick_reg].len
                                    + tab_reg[pick_reg + 1'b1].len;
                                merge_prev_reg <= 1'b0;
                                idx_reg   <= CNT_W'(pick_reg) + 1'b1;
                                sfrom_reg <= count_reg - 1'b1;
                                count_reg <= count_reg - 1'b1;
                            end
                        end
                        else if (pick_reg != '0 && !tab_reg[pick_reg - 1'b1].used)
                        begin
                            tab_reg[pick_reg - 1'b1].len <= tab_reg[pick_reg - 1'b1].len
                                + tab_reg[pick_reg].len;
                            merge_prev_reg <= 1'b0;
                            idx_reg   <= CNT_W'(pick_reg);
                            sfrom_reg <= count_reg - 1'b1;
                            count_reg <= count_reg - 1'b1;
                        end
                        else
                        begin
                            merge_prev_reg <= 1'b0;
                            sfrom_reg <= count_reg;
                            idx_reg   <= count_reg;
                        end
                    end
                end
                S_SHIFT:
                begin
                    if (sdir_reg)
                    begin
                        // insert: move rows up from the top down to sfrom
                        if (idx_reg == sfrom_reg)
                            tab_reg[idx_i] <= ins_reg;
                        else
                        begin
                            tab_reg[idx_i] <= tab_reg[idx_i - 1'b1];
                            idx_reg <= idx_reg - 1'b1;
                        end
                    end
                    else if (idx_reg != sfrom_reg)
                    begin
                        // remove: pull rows down, by two after a double merge
                        if (merge_prev_reg)
                            tab_reg[idx_i] <= tab_reg[idx_i + IDX_W'(2)];
                        else
                            tab_reg[idx_i] <= tab_reg[idx_i + 1'b1];
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    `VPA_ASSERT_NEVER(a_out_only_in_out, clk, rst_n,
        out_valid && state_reg != S_OUT, "output valid outside output state")
    `VPA_ASSERT_IMPL(a_count_nonzero, clk, rst_n, count_reg != '0, "segment count zero")
    `VPA_ASSERT_IMPL(a_pop_idle, clk, rst_n, q_pop |=> state_reg != S_IDLE,
        "engine stayed idle after pop")
endmodule

>>> rtl/variable_partition_allocator_unit.sv
`timescale 1ns / 1ps
// Sequence: a zero-size word goes from idle straight to the response; any other
// word scans S rows (1..N), applies, then shifts M rows (0..N-1) before the
// response, with N live segments (at most 32).
// Throughput: one word at a time in the engine, the next starts after the
// response leaves; the front queue holds two more before req.ready drops.
// Reset: asynchronous active low; one free segment of 32 units, first fit.
// ----------------------------------------------------------------------------
// variable_partition_allocator_unit
// Segment allocator: first/best/worst fit with coalescing on release.
// ----------------------------------------------------------------------------
module variable_partition_allocator_unit
    import vpa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    vpa_if.sink      req,
    vpa_if.source    rsp,
    vpa_if.sink      cfg
);
    // request data: {operation, owner_id[7:0], request_size[5:0]}
    // response data: {status, start_address, segment_length}
    policy_t fit_policy_reg;
    logic    q_valid, q_pop;
    cmd_t    q_cmd;
    rsp_t    r;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fit_policy_reg <= POL_FIRST;
        else if (cfg.valid)
            fit_policy_reg <= policy_t'(cfg.data[1:0]);
    end

    vpa_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .in_op    (req.data[14]),
        .in_owner (req.data[13:6]),
        .in_size  (req.data[5:0]),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_cmd    (q_cmd)
    );

    vpa_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .policy    (fit_policy_reg),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_cmd     (q_cmd),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_rsp   (r)
    );

    assign rsp.data = r;
endmodule

>>> tb/variable_partition_allocator_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_partition_allocator_unit_test
// Self-checking bench for the segment allocator. A directed table covers
// the error codes, the exact and oversize fits and the merge cases. Random
// allocate/release traffic then runs under every fit policy, with both
// channels idling at random in all but one phase. Each response word is
// checked against the directed table or an in-bench model of the segment table.
// ----------------------------------------------------------------------------
module variable_partition_allocator_unit_test
    import vpa_pkg::*;
();

    localparam int LIMIT      = 1000000;
    localparam int DRAIN_WAIT = 80;
    localparam int RAND_ITEMS = 1400;

    // Request word layout: operation, owner, size.
    typedef struct packed {
        logic       op;
        logic [7:0] owner;
        logic [5:0] size;
    } req_word_t;

    // Directed row; the expected response is filled in only where obvious.
    typedef struct {
        logic       op;
        logic [7:0] owner;
        logic [5:0] size;
        bit         fixed;
        status_t    status;
        logic [4:0] start;
        logic [5:0] len;
    } stim_row_t;

    logic clk;
    logic rst_n;

    vpa_if #(.W($bits(req_word_t))) req_ch ();
    vpa_if #(.W($bits(rsp_t)))      rsp_ch ();
    vpa_if #(.W(2))                 cfg_ch ();

    variable_partition_allocator_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source),
        .cfg   (cfg_ch.sink)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Segment table mirror
    // ------------------------------------------------------------------
    logic [4:0] seg_start [MEM_UNITS];
    logic [5:0] seg_len   [MEM_UNITS];
    logic [7:0] seg_owner [MEM_UNITS];
    bit         seg_used  [MEM_UNITS];
    int         seg_n;
    policy_t    fit_mode;

    rsp_t       pending_rsp [$];
    int         fail_count;
    int         cycle_count = 0;
    bit         calm;         // no idling on either side
    bit         hold_rsp;     // request a long receiver hold-off

    function automatic void drop_seg(input int idx);
        for (int i = idx; i + 1 < seg_n; i++)
        begin
            seg_start[i] = seg_start[i + 1];
            seg_len[i]   = seg_len[i + 1];
            seg_owner[i] = seg_owner[i + 1];
            seg_used[i]  = seg_used[i + 1];
        end
        seg_n--;
    endfunction

    // Applies one request to the mirror and returns the response word.
    function automatic rsp_t allocate_or_release(input req_word_t w);
        rsp_t r;
        int   pick;
        bit   found;
        int   rem;
        r     = '0;
        pick  = 0;
        found = 1'b0;
        if (w.op == OP_ALLOC)
        begin
            if (w.size == 0)
            begin
                r.status = ST_ZERO;
                return r;
            end
            for (int i = 0; i < seg_n; i++)
            begin
                if (seg_used[i] || seg_len[i] < w.size)
                    continue;
                if (!found)
                begin
                    pick  = i;
                    found = 1'b1;
                end
                else if (fit_mode == POL_BEST && seg_len[i] < seg_len[pick])
                    pick = i;
                else if (fit_mode == POL_WORST && seg_len[i] > seg_len[pick])
                    pick = i;
                // first fit (and the spare code) stops at the first hit
                if (fit_mode == POL_FIRST || fit_mode == POL_ALT)
                    break;
            end
            if (!found)
            begin
                r.status = ST_NO_FIT;
                return r;
            end
            rem = seg_len[pick] - w.size;
            r.status         = ST_DONE;
            r.start_address  = seg_start[pick];
            r.segment_length = w.size;
            seg_used[pick]   = 1'b1;
            seg_owner[pick]  = w.owner;
            seg_len[pick]    = w.size;
            // remainder goes right after the granted segment
            if (rem > 0 && seg_n < MEM_UNITS)
            begin
                for (int i = seg_n; i > pick + 1; i--)
                begin
                    seg_start[i] = seg_start[i - 1];
                    seg_len[i]   = seg_len[i - 1];
                    seg_owner[i] = seg_owner[i - 1];
                    seg_used[i]  = seg_used[i - 1];
                end
                seg_start[pick + 1] = r.start_address + w.size;
                seg_len[pick + 1]   = 6'(rem);
                seg_owner[pick + 1] = '0;
                seg_used[pick + 1]  = 1'b0;
                seg_n++;
            end
            return r;
        end
        for (int i = 0; i < seg_n; i++)
        begin
            if (seg_used[i] && seg_owner[i] == w.owner)
            begin
                pick  = i;
                found = 1'b1;
                break;
            end
        end
        if (!found)
        begin
            r.status = ST_NO_OWNER;
            return r;
        end
        // reported length is the one before merging
        r.status         = ST_DONE;
        r.start_address  = seg_start[pick];
        r.segment_length = seg_len[pick];
        seg_used[pick]   = 1'b0;
        seg_owner[pick]  = '0;
        if (pick + 1 < seg_n && !seg_used[pick + 1])
        begin
            seg_len[pick] += seg_len[pick + 1];
            drop_seg(pick + 1);
        end
        if (pick > 0 && !seg_used[pick - 1])
        begin
            seg_len[pick - 1] += seg_len[pick];
            drop_seg(pick);
        end
        return r;
    endfunction

    function automatic bit idle_now();
        return !calm && ($urandom_range(0, 99) < 31);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch %s: got %0d, want %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Offers one word; valid stays high when the next word follows at once.
    task automatic send_word(input req_word_t w, input bit fixed, input rsp_t want);
        rsp_t got_model;
        while (idle_now())
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= w;
        @(negedge clk);
        while (!req_ch.ready)
            @(negedge clk);
        @(posedge clk);
        got_model = allocate_or_release(w);
        pending_rsp.push_back(fixed ? want : got_model);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_policy(input policy_t p);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= p;
        @(negedge clk);
        while (!cfg_ch.ready)
            @(negedge clk);
        @(posedge clk);
        cfg_ch.valid <= 1'b0;
        fit_mode = p;
    endtask

    // Mostly small allocations and releases of live owners.
    function automatic req_word_t random_word();
        req_word_t w;
        int        live [$];
        int        pct;
        w   = '0;
        pct = $urandom_range(0, 99);
        w.op = ($urandom_range(0, 99) < 45) ? OP_RELEASE : OP_ALLOC;
        w.owner = (pct < 60) ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
        if (pct < 75)
            w.size = 6'($urandom_range(1, 8));
        else if (pct < 90)
            w.size = 6'($urandom_range(9, 32));
        else
            w.size = 6'($urandom_range(0, 63));
        if (w.op == OP_RELEASE && $urandom_range(0, 99) < 80)
        begin
            for (int i = 0; i < seg_n; i++)
                if (seg_used[i])
                    live.push_back(i);
            if (live.size() != 0)
                w.owner = seg_owner[live[$urandom_range(0, live.size() - 1)]];
        end
        return w;
    endfunction

    stim_row_t directed [] = '{
        // after reset: one free segment of 32
        '{OP_ALLOC,   8'd0,   6'd0,  1, ST_ZERO,     5'd0, 6'd0},
        '{OP_RELEASE, 8'd5,   6'd0,  1, ST_NO_OWNER, 5'd0, 6'd0},
        '{OP_ALLOC,   8'd1,   6'd33, 1, ST_NO_FIT,   5'd0, 6'd0},
        '{OP_ALLOC,   8'd255, 6'd63, 1, ST_NO_FIT,   5'd0, 6'd0},
        '{OP_ALLOC,   8'd255, 6'd32, 1, ST_DONE,     5'd0, 6'd32},
        '{OP_ALLOC,   8'd3,   6'd1,  1, ST_NO_FIT,   5'd0, 6'd0},
        '{OP_RELEASE, 8'd255, 6'd63, 1, ST_DONE,     5'd0, 6'd32},
        '{OP_RELEASE, 8'd255, 6'd0,  1, ST_NO_OWNER, 5'd0, 6'd0},
        // build a fragmented table, then merge both ways
        '{OP_ALLOC,   8'd1,   6'd4,  0, ST_DONE, 5'd0, 6'd0},
        '{OP_ALLOC,   8'd2,   6'd6,  0, ST_DONE, 5'd0, 6'd0},
        '{OP_ALLOC,   8'd3,   6'd2,  0, ST_DONE, 5'd0, 6'd0},
        '{OP_ALLOC,   8'd4,   6'd8,  0, ST_DONE, 5'd0, 6'd0},
        '{OP_ALLOC,   8'd1,   6'd3,  0, ST_DONE, 5'd0, 6'd0},
        '{OP_RELEASE, 8'd1,   6'd0,  0, ST_DONE, 5'd0, 6'd0},
        '{OP_RELEASE, 8'd3,   6'd0,  0, ST_DONE, 5'd0, 6'd0},
        '{OP_RELEASE, 8'd2,   6'd0,  0, ST_DONE, 5'd0, 6'd0},
        '{OP_ALLOC,   8'd170, 6'd10, 0, ST_DONE, 5'd0, 6'd0},
        '{OP_ALLOC,   8'd85,  6'd12, 0, ST_DONE, 5'd0, 6'd0},
        '{OP_RELEASE, 8'd1,   6'd0,  0, ST_DONE, 5'd0, 6'd0},
        '{OP_RELEASE, 8'd4,   6'd0,  0, ST_DONE, 5'd0, 6'd0},
        '{OP_RELEASE, 8'd170, 6'd0,  0, ST_DONE, 5'd0, 6'd0},
        '{OP_RELEASE, 8'd85,  6'd0,  0, ST_DONE, 5'd0, 6'd0}
    };

    policy_t phase_mode [] = '{POL_BEST, POL_WORST, POL_ALT, POL_FIRST,
                               POL_WORST, POL_BEST, POL_FIRST};

    initial
    begin
        req_word_t w;
        rsp_t      want;
        int        per_phase;
        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        calm         = 1'b0;
        hold_rsp     = 1'b0;
        fail_count   = 0;
        // mirror reset state: one free segment covering all units
        seg_n        = 1;
        seg_start[0] = '0;
        seg_len[0]   = 6'(MEM_UNITS);
        seg_owner[0] = '0;
        seg_used[0]  = 1'b0;
        fit_mode     = POL_FIRST;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[k])
        begin
            w    = '{directed[k].op, directed[k].owner, directed[k].size};
            want = '{directed[k].status, directed[k].start, directed[k].len};
            send_word(w, directed[k].fixed, want);
        end

        per_phase = RAND_ITEMS / phase_mode.size();
        foreach (phase_mode[p])
        begin
            write_policy(phase_mode[p]);
            calm = (p == 3);
            for (int n = 0; n < per_phase; n++)
            begin
                // receiver stalls long while words keep coming
                if (p == 0 && n == 20)
                    hold_rsp = 1'b1;
                // sender waits until all responses are back
                if (p == 1 && n == per_phase / 2)
                    drain();
                send_word(random_word(), 1'b0, '0);
            end
        end
        calm = 1'b0;

        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (pending_rsp.size() != 0)
            report_mismatch("responses left over", pending_rsp.size(), 0);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Response side: random ready, one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        bit   take;
        rsp_t got;
        rsp_t want;
        int   hold_left;
        rsp_ch.ready <= 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            take = rsp_ch.valid && rsp_ch.ready && rst_n;
            got  = rsp_t'(rsp_ch.data);
            @(posedge clk);
            if (take)
            begin
                if (pending_rsp.size() == 0)
                    report_mismatch("unexpected response word", 1, 0);
                else
                begin
                    want = pending_rsp.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.start_address !== want.start_address)
                        report_mismatch("start_address", got.start_address,
                                        want.start_address);
                    if (got.segment_length !== want.segment_length)
                        report_mismatch("segment_length", got.segment_length,
                                        want.segment_length);
                end
            end
            if (hold_rsp)
            begin
                hold_rsp  = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= !idle_now();
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule

>>> files.f
+incdir+rtl
rtl/vpa_pkg.sv
rtl/vpa_if.sv
rtl/vpa_front.sv
rtl/vpa_engine.sv
rtl/variable_partition_allocator_unit.sv
tb/variable_partition_allocator_unit_test.sv
